// File: hdl/qalu_pkg.sv
package qalu_pkg;

	localparam int COMP_WIDTH = 16;
	localparam int FRAC_BITS  = 14;
	localparam int PROD_BITS  = 2 * COMP_WIDTH;
	localparam int ACC_BITS   = PROD_BITS + 2;
	localparam int SUM_BITS   = PROD_BITS + 1;
	localparam int ROOT_BITS  = COMP_WIDTH + 1;
	localparam int TRIAL_BITS = 2 * ROOT_BITS + 1;
	localparam int NUM_BITS   = COMP_WIDTH + FRAC_BITS;
	localparam int QUO_BITS   = FRAC_BITS + 1;
	localparam int DVS_BITS   = NUM_BITS + 1;

	localparam logic [1:0] CMD_MUL  = 2'd0;
	localparam logic [1:0] CMD_CONJ = 2'd1;
	localparam logic [1:0] CMD_NORM = 2'd2;

	typedef struct packed {
		logic                               vld;
		logic [1:0]                         cmd;
		logic [3:0][COMP_WIDTH-1:0]         a;
		logic [3:0][COMP_WIDTH-1:0]         r;
		logic                               sat;
		logic                               zn;
		logic [SUM_BITS-1:0]                rem;
		logic [ROOT_BITS-1:0]               root;
		logic [3:0][NUM_BITS-1:0]           num;
		logic [3:0][QUO_BITS-1:0]           quo;
	} item_t;

endpackage

// File: hdl/qalu_front.sv
module qalu_front (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     en,
	input  logic                                     in_valid,
	input  logic [1:0]                               command,
	input  logic signed [qalu_pkg::COMP_WIDTH-1:0]   a_w,
	input  logic signed [qalu_pkg::COMP_WIDTH-1:0]   a_x,
	input  logic signed [qalu_pkg::COMP_WIDTH-1:0]   a_y,
	input  logic signed [qalu_pkg::COMP_WIDTH-1:0]   a_z,
	input  logic signed [qalu_pkg::COMP_WIDTH-1:0]   b_w,
	input  logic signed [qalu_pkg::COMP_WIDTH-1:0]   b_x,
	input  logic signed [qalu_pkg::COMP_WIDTH-1:0]   b_y,
	input  logic signed [qalu_pkg::COMP_WIDTH-1:0]   b_z,
	output qalu_pkg::item_t                          out_s2
);
	import qalu_pkg::*;

	localparam logic signed [ACC_BITS-1:0] RND  = (ACC_BITS'(1) <<< FRAC_BITS) - ACC_BITS'(1);
	localparam logic signed [ACC_BITS-1:0] MAXV = (ACC_BITS'(1) <<< (COMP_WIDTH-1)) - ACC_BITS'(1);
	localparam logic signed [ACC_BITS-1:0] MINV = -(ACC_BITS'(1) <<< (COMP_WIDTH-1));
	localparam logic [COMP_WIDTH-1:0] CMIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};
	localparam logic [COMP_WIDTH-1:0] CMAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};

	logic [3:0][COMP_WIDTH-1:0]      a_in, b_in;
	logic [3:0][3:0][PROD_BITS-1:0]  prod_d;
	logic [3:0][PROD_BITS-2:0]       sq_d;
	logic signed [PROD_BITS-1:0]     sqp;

	logic                            vld_s1;
	logic [1:0]                      cmd_s1;
	logic [3:0][COMP_WIDTH-1:0]      a_s1;
	logic [3:0][3:0][PROD_BITS-1:0]  prod_s1;
	logic [3:0][PROD_BITS-2:0]       sq_s1;

	logic signed [ACC_BITS-1:0]      acc [4];
	logic signed [ACC_BITS-1:0]      adj, sh;
	logic [SUM_BITS-1:0]             ssum;
	logic [COMP_WIDTH-1:0]           mag;
	item_t                           nxt;

	function automatic logic signed [ACC_BITS-1:0] ext(input logic [PROD_BITS-1:0] p);
		ext = {{(ACC_BITS-PROD_BITS){p[PROD_BITS-1]}}, p};
	endfunction

	always_comb begin
		a_in = {a_z, a_y, a_x, a_w};
		b_in = {b_z, b_y, b_x, b_w};
		sqp  = '0;
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				prod_d[i][j] = $signed(a_in[i]) * $signed(b_in[j]);
			end
			sqp      = $signed(a_in[i]) * $signed(a_in[i]);
			sq_d[i]  = sqp[PROD_BITS-2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1  <= command;
			a_s1    <= a_in;
			prod_s1 <= prod_d;
			sq_s1   <= sq_d;
		end
	end

	// Hamilton product terms
	always_comb begin
		acc[0] = ext(prod_s1[0][0]) - ext(prod_s1[1][1]) - ext(prod_s1[2][2])
			- ext(prod_s1[3][3]);
		acc[1] = ext(prod_s1[0][1]) + ext(prod_s1[1][0]) + ext(prod_s1[2][3])
			- ext(prod_s1[3][2]);
		acc[2] = ext(prod_s1[0][2]) - ext(prod_s1[1][3]) + ext(prod_s1[2][0])
			+ ext(prod_s1[3][1]);
		acc[3] = ext(prod_s1[0][3]) + ext(prod_s1[1][2]) - ext(prod_s1[2][1])
			+ ext(prod_s1[3][0]);
	end

	always_comb begin
		nxt      = '0;
		nxt.vld  = vld_s1;
		nxt.cmd  = cmd_s1;
		nxt.a    = a_s1;
		nxt.r    = a_s1;
		adj      = '0;
		sh       = '0;
		mag      = '0;
		ssum     = SUM_BITS'(sq_s1[0]) + SUM_BITS'(sq_s1[1]) + SUM_BITS'(sq_s1[2])
			+ SUM_BITS'(sq_s1[3]);
		nxt.rem  = ssum;
		for (int i = 0; i < 4; i++) begin
			mag        = a_s1[i][COMP_WIDTH-1] ? (~a_s1[i] + COMP_WIDTH'(1)) : a_s1[i];
			nxt.num[i] = {mag, {FRAC_BITS{1'b0}}};
		end
		case (cmd_s1)
			CMD_MUL: begin
				for (int i = 0; i < 4; i++) begin
					adj = acc[i] + (acc[i][ACC_BITS-1] ? RND : ACC_BITS'(0));
					sh  = adj >>> FRAC_BITS;
					if (sh > MAXV) begin
						nxt.r[i] = CMAX;
						nxt.sat  = 1'b1;
					end else if (sh < MINV) begin
						nxt.r[i] = CMIN;
						nxt.sat  = 1'b1;
					end else begin
						nxt.r[i] = sh[COMP_WIDTH-1:0];
					end
				end
			end
			CMD_CONJ: begin
				for (int i = 1; i < 4; i++) begin
					if (a_s1[i] == CMIN) begin
						nxt.r[i] = CMAX;
						nxt.sat  = 1'b1;
					end else begin
						nxt.r[i] = -a_s1[i];
					end
				end
			end
			CMD_NORM: begin
				nxt.zn = (ssum == '0);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_s2 <= '0;
		end else if (en) begin
			out_s2 <= nxt;
		end
	end

endmodule

// File: hdl/qalu_sqrt.sv
module qalu_sqrt (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  qalu_pkg::item_t   in_item,
	output qalu_pkg::item_t   out_item
);
	import qalu_pkg::*;

	item_t root_s [ROOT_BITS];

	for (genvar g = 0; g < ROOT_BITS; g++) begin : g_bit
		localparam int BIT = ROOT_BITS - 1 - g;
		item_t                 prev, nxt;
		logic [TRIAL_BITS-1:0] trial, remx;

		if (g == 0) begin : g_first
			assign prev = in_item;
		end else begin : g_rest
			assign prev = root_s[g-1];
		end

		always_comb begin
			trial = (TRIAL_BITS'(prev.root) << (BIT + 1)) + (TRIAL_BITS'(1) << (2 * BIT));
			remx  = TRIAL_BITS'(prev.rem);
			nxt   = prev;
			if (remx >= trial) begin
				nxt.rem  = SUM_BITS'(remx - trial);
				nxt.root = prev.root | (ROOT_BITS'(1) << BIT);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				root_s[g] <= '0;
			end else if (en) begin
				root_s[g] <= nxt;
			end
		end
	end

	assign out_item = root_s[ROOT_BITS-1];

endmodule

// File: hdl/qalu_div.sv
module qalu_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  qalu_pkg::item_t   in_item,
	output qalu_pkg::item_t   out_item
);
	import qalu_pkg::*;

	item_t quo_s [QUO_BITS];
	item_t fin_s;
	item_t fin_d;

	for (genvar g = 0; g < QUO_BITS; g++) begin : g_bit
		localparam int BIT = QUO_BITS - 1 - g;
		item_t               prev, nxt;
		logic [DVS_BITS-1:0] dvs;

		if (g == 0) begin : g_first
			assign prev = in_item;
		end else begin : g_rest
			assign prev = quo_s[g-1];
		end

		always_comb begin
			dvs = DVS_BITS'(prev.root) << BIT;
			nxt = prev;
			for (int l = 0; l < 4; l++) begin
				if (DVS_BITS'(prev.num[l]) >= dvs) begin
					nxt.num[l] = NUM_BITS'(DVS_BITS'(prev.num[l]) - dvs);
					nxt.quo[l] = prev.quo[l] | (QUO_BITS'(1) << BIT);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				quo_s[g] <= '0;
			end else if (en) begin
				quo_s[g] <= nxt;
			end
		end
	end

	always_comb begin
		fin_d = quo_s[QUO_BITS-1];
		if (fin_d.cmd == CMD_NORM && !fin_d.zn) begin
			for (int l = 0; l < 4; l++) begin
				fin_d.r[l] = fin_d.a[l][COMP_WIDTH-1] ? -COMP_WIDTH'(fin_d.quo[l])
					: COMP_WIDTH'(fin_d.quo[l]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_s <= '0;
		end else if (en) begin
			fin_s <= fin_d;
		end
	end

	assign out_item = fin_s;

	a_zn_norm_only: assert property (@(posedge clk) disable iff (!arst_n)
		fin_s.vld && fin_s.zn |-> fin_s.cmd == CMD_NORM)
		else $error("zero flag on non-normalize word");
	a_sat_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		fin_s.vld && fin_s.sat |-> fin_s.cmd == CMD_MUL || fin_s.cmd == CMD_CONJ)
		else $error("saturation flag on wrong command");
	a_zn_pass: assert property (@(posedge clk) disable iff (!arst_n)
		fin_s.vld && fin_s.zn |-> fin_s.r == fin_s.a)
		else $error("zero-magnitude word not passed through");

endmodule

// File: hdl/quaternion_alu.sv
// Quaternion ALU: multiply (Hamilton product a*b), conjugate a, or normalize a, on signed
// Q2.14 components. Fully pipelined, one word accepted per clock while the output is not stalled:
// two stages of products and sums, 17 square-root stages (one root bit each), 15 divider
// stages (one quotient bit per stage, four lanes) and an output register. A stall on the
// output holds the whole pipeline; in_ready is low only while the output word waits.
module quaternion_alu (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic [1:0]                               command,
	input  logic signed [qalu_pkg::COMP_WIDTH-1:0]   a_w,
	input  logic signed [qalu_pkg::COMP_WIDTH-1:0]   a_x,
	input  logic signed [qalu_pkg::COMP_WIDTH-1:0]   a_y,
	input  logic signed [qalu_pkg::COMP_WIDTH-1:0]   a_z,
	input  logic signed [qalu_pkg::COMP_WIDTH-1:0]   b_w,
	input  logic signed [qalu_pkg::COMP_WIDTH-1:0]   b_x,
	input  logic signed [qalu_pkg::COMP_WIDTH-1:0]   b_y,
	input  logic signed [qalu_pkg::COMP_WIDTH-1:0]   b_z,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic signed [qalu_pkg::COMP_WIDTH-1:0]   r_w,
	output logic signed [qalu_pkg::COMP_WIDTH-1:0]   r_x,
	output logic signed [qalu_pkg::COMP_WIDTH-1:0]   r_y,
	output logic signed [qalu_pkg::COMP_WIDTH-1:0]   r_z,
	output logic                                     zero_norm,
	output logic                                     saturated
);
	import qalu_pkg::*;

	logic  en;
	item_t front_item, root_item, fin_item;

	assign en       = !fin_item.vld || out_ready;
	assign in_ready = en;

	qalu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.command  (command),
		.a_w      (a_w),
		.a_x      (a_x),
		.a_y      (a_y),
		.a_z      (a_z),
		.b_w      (b_w),
		.b_x      (b_x),
		.b_y      (b_y),
		.b_z      (b_z),
		.out_s2   (front_item)
	);

	qalu_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_item  (front_item),
		.out_item (root_item)
	);

	qalu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_item  (root_item),
		.out_item (fin_item)
	);

	assign out_valid = fin_item.vld;
	assign r_w       = fin_item.r[0];
	assign r_x       = fin_item.r[1];
	assign r_y       = fin_item.r[2];
	assign r_z       = fin_item.r[3];
	assign zero_norm = fin_item.zn;
	assign saturated = fin_item.sat;

endmodule
